FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used across the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define HSRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("heap sorter check failed");

// consequent must hold in the same cycle as the antecedent
`define HSRT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heap sorter check failed");

`endif

FILE: rtl/hsrt_pkg.sv
// ----------------------------------------------------------------------------
// Heap sorter package
// Sequencer state type and output key width shared by the heap sorter modules.
// ----------------------------------------------------------------------------
package hsrt_pkg;

  localparam int unsigned OutKeyBits = 32;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SF_RN,
    ST_SF_LD,
    ST_SF_CHK,
    ST_SF_R,
    ST_SF_RC,
    ST_SF_C,
    ST_SF_END,
    ST_EX_R0,
    ST_EX_RL,
    ST_EX_W,
    ST_EM_RD,
    ST_EM_LD
  } state_e;

endpackage

FILE: rtl/hsrt_store.sv
// ----------------------------------------------------------------------------
// Heap sorter key store
// Single write port, single registered read port key memory.
// ----------------------------------------------------------------------------
module hsrt_store #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned IDX_W    = $clog2(CAPACITY)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IDX_W-1:0]    waddr_i,
  input  logic [KEY_BITS-1:0] wdata_i,
  input  logic [IDX_W-1:0]    raddr_i,
  output logic [KEY_BITS-1:0] rdata_o
);

  logic [KEY_BITS-1:0] mem [CAPACITY];
  logic [KEY_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/hsrt_seq.sv
// ----------------------------------------------------------------------------
// Heap sorter sequencer
// Loads keys, runs heap build and extraction through one shared comparator,
// and streams the sorted keys through the output register.
// ----------------------------------------------------------------------------
module hsrt_seq
  import hsrt_pkg::*;
#(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned IDX_W    = $clog2(CAPACITY),
  parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [OutKeyBits-1:0] key_in_i,
  input  logic                  is_last_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [OutKeyBits-1:0] key_out_o,
  output logic                  final_out_o,
  output logic                  overflowed_o,
  output logic                  mem_we_o,
  output logic [IDX_W-1:0]      mem_waddr_o,
  output logic [KEY_BITS-1:0]   mem_wdata_o,
  output logic [IDX_W-1:0]      mem_raddr_o,
  input  logic [KEY_BITS-1:0]   mem_rdata_i
);

  localparam int unsigned CW = CNT_W + 1;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      fill_q, fill_d;
  logic                  drop_q, drop_d;
  logic [CNT_W-1:0]      hend_q, hend_d;
  logic [IDX_W-1:0]      node_q, node_d;
  logic [IDX_W-1:0]      bidx_q, bidx_d;
  logic [IDX_W-1:0]      k_q, k_d;
  logic                  ext_q, ext_d;
  logic [KEY_BITS-1:0]   cur_q, cur_d;
  logic [KEY_BITS-1:0]   bigk_q, bigk_d;
  logic [IDX_W-1:0]      big_q, big_d;
  logic                  out_valid_q, out_valid_d;
  logic [OutKeyBits-1:0] out_key_q, out_key_d;
  logic                  out_final_q, out_final_d;
  logic                  out_ovf_q, out_ovf_d;

  logic                  in_xfer;
  logic [63:0]           key_in_wide;
  logic [63:0]           key_rd_wide;
  logic [CW-1:0]         left_w, right_w, hend_w;
  logic                  has_left, has_right;
  logic [CNT_W-1:0]      hend_m1;
  logic [CNT_W-1:0]      k_next;
  logic                  last_k;
  logic                  can_load;
  logic [KEY_BITS-1:0]   cmp_a, cmp_b;
  logic                  cmp_lt;
  state_e                after_sift;

  assign in_stall_o   = (state_q != ST_LOAD);
  assign in_xfer      = in_valid_i && !in_stall_o;
  assign key_in_wide  = 64'(key_in_i);
  assign key_rd_wide  = 64'(mem_rdata_i);

  assign left_w    = CW'({node_q, 1'b1});
  assign right_w   = left_w + CW'(1);
  assign hend_w    = CW'(hend_q);
  assign has_left  = left_w < hend_w;
  assign has_right = right_w < hend_w;
  assign hend_m1   = hend_q - CNT_W'(1);
  assign k_next    = CNT_W'(k_q) + CNT_W'(1);
  assign last_k    = (k_next == fill_q);
  assign can_load  = !out_valid_q || !out_stall_i;

  // shared key comparator
  always_comb begin
    if (state_q == ST_SF_RC) begin
      cmp_a = bigk_q;
      cmp_b = mem_rdata_i;
    end else begin
      cmp_a = cur_q;
      cmp_b = bigk_q;
    end
  end
  assign cmp_lt = cmp_a < cmp_b;

  assign after_sift = (hend_q > CNT_W'(1)) ? ST_EX_R0 : ST_EM_RD;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      fill_q      <= '0;
      drop_q      <= 1'b0;
      hend_q      <= '0;
      node_q      <= '0;
      bidx_q      <= '0;
      k_q         <= '0;
      ext_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      drop_q      <= drop_d;
      hend_q      <= hend_d;
      node_q      <= node_d;
      bidx_q      <= bidx_d;
      k_q         <= k_d;
      ext_q       <= ext_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    bigk_q      <= bigk_d;
    big_q       <= big_d;
    out_key_q   <= out_key_d;
    out_final_q <= out_final_d;
    out_ovf_q   <= out_ovf_d;
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    drop_d      = drop_q;
    hend_d      = hend_q;
    node_d      = node_q;
    bidx_d      = bidx_q;
    k_d         = k_q;
    ext_d       = ext_q;
    cur_d       = cur_q;
    bigk_d      = bigk_q;
    big_d       = big_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_key_d   = out_key_q;
    out_final_d = out_final_q;
    out_ovf_d   = out_ovf_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = node_q;
    mem_wdata_o = cur_q;
    mem_raddr_o = node_q;

    unique case (state_q)
      ST_LOAD: begin
        mem_waddr_o = fill_q[IDX_W-1:0];
        mem_wdata_o = key_in_wide[KEY_BITS-1:0];
        if (in_xfer) begin
          if (fill_q < CNT_W'(CAPACITY)) begin
            mem_we_o = 1'b1;
            fill_d   = fill_q + CNT_W'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (is_last_i) begin
            hend_d  = fill_d;
            bidx_d  = IDX_W'(fill_d >> 1);
            node_d  = IDX_W'(fill_d >> 1);
            ext_d   = 1'b0;
            state_d = ST_SF_RN;
          end
        end
      end
      ST_SF_RN: begin
        mem_raddr_o = node_q;
        state_d     = ST_SF_LD;
      end
      ST_SF_LD: begin
        cur_d   = mem_rdata_i;
        state_d = ST_SF_CHK;
      end
      ST_SF_CHK: begin
        mem_raddr_o = left_w[IDX_W-1:0];
        state_d     = has_left ? ST_SF_R : ST_SF_END;
      end
      ST_SF_R: begin
        bigk_d      = mem_rdata_i;
        big_d       = left_w[IDX_W-1:0];
        mem_raddr_o = right_w[IDX_W-1:0];
        state_d     = has_right ? ST_SF_RC : ST_SF_C;
      end
      ST_SF_RC: begin
        if (cmp_lt) begin
          bigk_d = mem_rdata_i;
          big_d  = right_w[IDX_W-1:0];
        end
        state_d = ST_SF_C;
      end
      ST_SF_C: begin
        // move the larger child up into the hole
        if (cmp_lt) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = node_q;
          mem_wdata_o = bigk_q;
          node_d      = big_q;
          state_d     = ST_SF_CHK;
        end else begin
          state_d = ST_SF_END;
        end
      end
      ST_SF_END: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = node_q;
        mem_wdata_o = cur_q;
        if (ext_q) begin
          state_d = after_sift;
        end else if (bidx_q == '0) begin
          ext_d   = 1'b1;
          state_d = after_sift;
        end else begin
          bidx_d  = bidx_q - IDX_W'(1);
          node_d  = bidx_q - IDX_W'(1);
          state_d = ST_SF_RN;
        end
      end
      ST_EX_R0: begin
        mem_raddr_o = '0;
        state_d     = ST_EX_RL;
      end
      ST_EX_RL: begin
        bigk_d      = mem_rdata_i;
        mem_raddr_o = hend_m1[IDX_W-1:0];
        state_d     = ST_EX_W;
      end
      ST_EX_W: begin
        // old root goes to the tail, old tail is sifted from the root
        cur_d       = mem_rdata_i;
        mem_we_o    = 1'b1;
        mem_waddr_o = hend_m1[IDX_W-1:0];
        mem_wdata_o = bigk_q;
        hend_d      = hend_m1;
        node_d      = '0;
        state_d     = ST_SF_CHK;
      end
      ST_EM_RD: begin
        mem_raddr_o = k_q;
        state_d     = ST_EM_LD;
      end
      ST_EM_LD: begin
        mem_raddr_o = k_q;
        if (can_load) begin
          out_valid_d = 1'b1;
          out_key_d   = key_rd_wide[OutKeyBits-1:0];
          out_final_d = last_k;
          out_ovf_d   = drop_q;
          if (last_k) begin
            fill_d  = '0;
            drop_d  = 1'b0;
            hend_d  = '0;
            node_d  = '0;
            bidx_d  = '0;
            k_d     = '0;
            ext_d   = 1'b0;
            state_d = ST_LOAD;
          end else begin
            k_d     = k_q + IDX_W'(1);
            state_d = ST_EM_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign key_out_o    = out_key_q;
  assign final_out_o  = out_final_q;
  assign overflowed_o = out_ovf_q;

endmodule

FILE: rtl/heap_sorter_unit.sv
// ----------------------------------------------------------------------------
// Heap sorter unit
// Collects a batch of keys, heapsorts them in place and emits them ascending.
// ----------------------------------------------------------------------------
//  channel | signals                                                       | direction
//  in      | in_valid_i, in_stall_o, key_in_i, is_last_i                   | keys in
//  out     | out_valid_o, out_stall_i, key_out_o, final_out_o, overflowed_o | sorted keys out
//
//  Loading takes a key whenever in_valid_i is high. The keys are then
//  heapsorted on the one-read, one-write key memory and the shared
//  comparator. Emission loads each key into the output register unless
//  out_stall_i holds it. in_stall_o is high from the last key until the
//  final result is loaded into the output register. Reset is asynchronous
//  and needs no clearing pass.
// ----------------------------------------------------------------------------
module heap_sorter_unit
  import hsrt_pkg::*;
#(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [OutKeyBits-1:0] key_in_i,
  input  logic                  is_last_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [OutKeyBits-1:0] key_out_o,
  output logic                  final_out_o,
  output logic                  overflowed_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [KEY_BITS-1:0] mem_wdata;
  logic [IDX_W-1:0]    mem_raddr;
  logic [KEY_BITS-1:0] mem_rdata;

  hsrt_seq #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .key_in_i     (key_in_i),
    .is_last_i    (is_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .key_out_o    (key_out_o),
    .final_out_o  (final_out_o),
    .overflowed_o (overflowed_o),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  hsrt_store #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .IDX_W    (IDX_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

FILE: rtl/hsrt_checker.sv
// ----------------------------------------------------------------------------
// Heap sorter checker
// Port-level checks on batch sequencing and the result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsrt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        is_last_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] key_out_o,
  input logic        final_out_o,
  input logic        overflowed_o
);

  logic        in_xfer;
  logic        out_held;
  logic [33:0] out_word;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_held = out_valid_o && out_stall_i;
  assign out_word = {key_out_o, final_out_o, overflowed_o};

  `HSRT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_word))
  `HSRT_ASSERT_NEXT(a_last_busy, clk_i, rst_ni, in_xfer && is_last_i, in_stall_o)
  `HSRT_ASSERT_NEXT(a_load_open, clk_i, rst_ni, in_xfer && !is_last_i, !in_stall_o)
  `HSRT_ASSERT_SAME(a_out_from_sort, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind heap_sorter_unit hsrt_checker u_hsrt_checker (.*);
